>>> sv/pid_filtered_derivative_antiwindup_macros.svh
// Assertion helpers for the block's top module.
`ifndef PID_FILTERED_DERIVATIVE_ANTIWINDUP_MACROS_SVH
`define PID_FILTERED_DERIVATIVE_ANTIWINDUP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PFD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pfd assertion failed");

// Next-cycle implication, checked outside reset.
`define PFD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pfd assertion failed");

`endif

>>> sv/pfd_pkg.sv
package pfd_pkg;

	localparam int VW = 32;
	localparam int FRAC = 16;
	localparam int DTF = 20;
	localparam int DTW = 24;
	localparam int IW = 48;
	localparam int AW = 17;
	localparam int RIW = 3;

	localparam logic [AW-1:0] ALPHA_ONE = AW'(65536);

	localparam logic [RIW-1:0] REG_GAIN_P = 3'd0;
	localparam logic [RIW-1:0] REG_GAIN_I = 3'd1;
	localparam logic [RIW-1:0] REG_GAIN_D = 3'd2;
	localparam logic [RIW-1:0] REG_GAIN_FF = 3'd3;
	localparam logic [RIW-1:0] REG_ALPHA = 3'd4;
	localparam logic [RIW-1:0] REG_OUT_MIN = 3'd5;
	localparam logic [RIW-1:0] REG_OUT_MAX = 3'd6;
	localparam logic [RIW-1:0] REG_OFFSET = 3'd7;

	localparam logic signed [VW-1:0] RST_GAIN_P = VW'(65536);
	localparam logic signed [VW-1:0] RST_GAIN_FF = VW'(65536);
	localparam logic signed [VW-1:0] RST_OUT_MIN = -VW'(65536000);
	localparam logic signed [VW-1:0] RST_OUT_MAX = VW'(65536000);

	typedef enum logic [3:0] {
		ST_IDLE, ST_P, ST_INC, ST_IT, ST_CDIV, ST_IT2,
		ST_RAW, ST_FA, ST_FB, ST_D, ST_FF, ST_SUM
	} state_t;

	typedef struct packed {
		logic start;
		logic signed [VW-1:0] x;
		logic signed [IW-1:0] y;
		logic sh_dt;
		logic wide;
	} mul_req_t;

	typedef struct packed {
		logic start;
		logic signed [VW+1:0] n;
		logic signed [VW-1:0] d;
		logic sh_dt;
		logic wide;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic signed [IW-1:0] res;
	} unit_sts_t;

	// Signed magnitude to a value saturated to the 32-bit or the 48-bit range.
	function automatic logic signed [IW-1:0] pack_sat(input logic neg, input logic [63:0] m,
			input logic wide);
		logic [63:0] hi;
		logic [63:0] lim;
		logic [63:0] mm;
		hi = wide ? ((64'd1 << (IW - 1)) - 64'd1) : ((64'd1 << (VW - 1)) - 64'd1);
		lim = hi + 64'd1;
		if (neg) begin
			mm = (m > lim) ? lim : m;
			return $signed(IW'(64'd0 - mm));
		end
		mm = (m > hi) ? hi : m;
		return $signed(IW'(mm));
	endfunction

	function automatic logic signed [VW-1:0] sat_v(input logic signed [VW:0] v);
		if (v[VW] != v[VW-1]) begin
			return v[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		end
		return v[VW-1:0];
	endfunction

endpackage

>>> sv/pfd_mul.sv
module pfd_mul (
	input logic clk,
	input logic arst_n,
	input pfd_pkg::mul_req_t req,
	output pfd_pkg::unit_sts_t sts
);
	import pfd_pkg::*;

	localparam int HW = IW / 2;

	logic [VW-1:0] ma_q;
	logic [IW-1:0] mb_q;
	logic neg_q, sh_q, wide_q;
	logic [VW+HW-1:0] p_q;
	logic [VW+IW-1:0] acc_q;
	logic [1:0] cnt_q;
	logic busy_q, done_q;
	logic signed [IW-1:0] res_q;
	logic [HW-1:0] half;

	assign half = cnt_q[0] ? mb_q[IW-1:HW] : mb_q[HW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The 48-bit operand goes through the multiplier in two halves.
	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q <= req.x[VW-1] ? VW'(-req.x) : VW'(req.x);
			mb_q <= req.y[IW-1] ? IW'(-req.y) : IW'(req.y);
			neg_q <= req.x[VW-1] ^ req.y[IW-1];
			sh_q <= req.sh_dt;
			wide_q <= req.wide;
		end else if (busy_q) begin
			unique case (cnt_q)
				2'd0: p_q <= (VW+HW)'(ma_q) * (VW+HW)'(half);
				2'd1: begin
					acc_q <= (VW+IW)'(p_q);
					p_q <= (VW+HW)'(ma_q) * (VW+HW)'(half);
				end
				2'd2: acc_q <= acc_q + ((VW+IW)'(p_q) << HW);
				default: res_q <= pack_sat(neg_q,
					sh_q ? 64'(acc_q >> DTF) : 64'(acc_q >> FRAC), wide_q);
			endcase
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.res = res_q;

endmodule

>>> sv/pfd_div.sv
module pfd_div (
	input logic clk,
	input logic arst_n,
	input pfd_pkg::div_req_t req,
	output pfd_pkg::unit_sts_t sts
);
	import pfd_pkg::*;

	localparam int NW = 56;
	localparam int STEPS = NW / 2;
	localparam int CW = $clog2(STEPS);

	logic [NW-1:0] num_q, q_q, q_next;
	logic [VW-1:0] dm_q, r_q;
	logic neg_q, wide_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic signed [IW-1:0] res_q;
	logic [VW+1:0] mn;
	logic [VW:0] r1, r1s, r2, r2s;
	logic ge1, ge2;

	assign mn = req.n[VW+1] ? (VW+2)'(-req.n) : (VW+2)'(req.n);

	// Two restoring steps per cycle.
	always_comb begin
		r1 = {r_q, num_q[NW-1]};
		ge1 = r1 >= {1'b0, dm_q};
		r1s = ge1 ? r1 - {1'b0, dm_q} : r1;
		r2 = {r1s[VW-1:0], num_q[NW-2]};
		ge2 = r2 >= {1'b0, dm_q};
		r2s = ge2 ? r2 - {1'b0, dm_q} : r2;
		q_next = {q_q[NW-3:0], ge1, ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.sh_dt ? (NW'(mn) << DTF) : (NW'(mn) << FRAC);
			dm_q <= req.d[VW-1] ? VW'(-req.d) : VW'(req.d);
			r_q <= '0;
			q_q <= '0;
			neg_q <= req.n[VW+1] ^ req.d[VW-1];
			wide_q <= req.wide;
		end else if (busy_q) begin
			num_q <= num_q << 2;
			r_q <= r2s[VW-1:0];
			q_q <= q_next;
			if (cnt_q == CW'(STEPS - 1)) begin
				res_q <= pack_sat(neg_q, 64'(q_next), wide_q);
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.res = res_q;

endmodule

>>> sv/pid_filtered_derivative_antiwindup.sv
// Channel   Handshake               Word
// in        in_valid / in_ready     mode, setpoint, measured_value, feedforward_value,
//                                   elapsed_time
// out       out_valid / out_ready   control_out
// cfg       cfg_we                  cfg_index, cfg_data
//
// A clear, a first sample or a zero elapsed time gives its result in the cycle after acceptance.
// A full sample runs up to eight multiplier passes and up to two divides, then a final sum. A zero
// gain_i skips the integral term, and an integral that is clamped back adds a divide and a further
// multiplier pass.
// arst_n clears the sequencer, the registers to their reset values and the controller state.
// A new word is taken only once the previous result has been taken at the output.
`include "pid_filtered_derivative_antiwindup_macros.svh"

module pid_filtered_derivative_antiwindup (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic mode,
	input logic signed [pfd_pkg::VW-1:0] setpoint,
	input logic signed [pfd_pkg::VW-1:0] measured_value,
	input logic signed [pfd_pkg::VW-1:0] feedforward_value,
	input logic [pfd_pkg::DTW-1:0] elapsed_time,
	output logic out_valid,
	input logic out_ready,
	output logic signed [pfd_pkg::VW-1:0] control_out,
	input logic cfg_we,
	input logic [pfd_pkg::RIW-1:0] cfg_index,
	input logic [pfd_pkg::VW-1:0] cfg_data
);
	import pfd_pkg::*;

	localparam int SW = VW + 4;

	logic signed [VW-1:0] gain_p_q, gain_i_q, gain_d_q, gain_ff_q;
	logic signed [VW-1:0] out_min_q, out_max_q, offset_q;
	logic [AW-1:0] alpha_q, alpha_c;

	logic started_q;
	logic signed [VW-1:0] prev_err_q, fd_q, last_q;
	logic signed [IW-1:0] integ_q;

	logic signed [VW-1:0] err_q, ffv_q, raw_q, tmp_q, out_q;
	logic [DTW-1:0] dt_q;
	logic signed [SW-1:0] sum_q;
	logic clamp_hi_q, issued_q, ovalid_q;

	state_t state_q, state_d;
	mul_req_t mreq;
	div_req_t dreq;
	unit_sts_t msts, dsts;

	logic accept, op_done, is_div;
	logic signed [IW-1:0] op_res;
	logic signed [VW-1:0] res_v, lc;
	logic signed [IW:0] isum;
	logic signed [SW-1:0] fsum;

	pfd_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .sts(msts));
	pfd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .sts(dsts));

	assign in_ready = (state_q == ST_IDLE) && !ovalid_q;
	assign accept = in_valid && in_ready;
	assign out_valid = ovalid_q;
	assign control_out = out_q;

	assign alpha_c = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign is_div = (state_q == ST_CDIV) || (state_q == ST_RAW);
	assign op_done = msts.done || dsts.done;
	assign op_res = is_div ? dsts.res : msts.res;
	assign res_v = op_res[VW-1:0];
	assign isum = (IW+1)'(integ_q) + (IW+1)'(msts.res);
	assign fsum = sum_q + SW'(offset_q);

	// The limit checks run against out_max first, so a sum above out_max and below out_min gets out_max.
	always_comb begin
		if (fsum > SW'(out_max_q)) begin
			lc = out_max_q;
		end else if (fsum < SW'(out_min_q)) begin
			lc = out_min_q;
		end else begin
			lc = fsum[VW-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !mode && started_q && (elapsed_time != '0)) begin
					state_d = ST_P;
				end
			end
			ST_P: if (op_done) state_d = ST_INC;
			ST_INC: if (op_done) state_d = (gain_i_q == '0) ? ST_RAW : ST_IT;
			ST_IT: begin
				if (op_done) begin
					state_d = (res_v > out_max_q || res_v < out_min_q) ? ST_CDIV : ST_RAW;
				end
			end
			ST_CDIV: if (op_done) state_d = ST_IT2;
			ST_IT2: if (op_done) state_d = ST_RAW;
			ST_RAW: if (op_done) state_d = ST_FA;
			ST_FA: if (op_done) state_d = ST_FB;
			ST_FB: if (op_done) state_d = ST_D;
			ST_D: if (op_done) state_d = ST_FF;
			ST_FF: if (op_done) state_d = ST_SUM;
			ST_SUM: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mreq = '0;
		dreq = '0;
		unique case (state_q)
			ST_P: begin
				mreq.x = gain_p_q;
				mreq.y = IW'(err_q);
			end
			ST_INC: begin
				mreq.x = err_q;
				mreq.y = $signed(IW'(dt_q));
				mreq.sh_dt = 1'b1;
				mreq.wide = 1'b1;
			end
			ST_IT, ST_IT2: begin
				mreq.x = gain_i_q;
				mreq.y = integ_q;
			end
			ST_FA: begin
				mreq.x = $signed(VW'(alpha_c));
				mreq.y = IW'(fd_q);
			end
			ST_FB: begin
				mreq.x = $signed(VW'(ALPHA_ONE - alpha_c));
				mreq.y = IW'(raw_q);
			end
			ST_D: begin
				mreq.x = gain_d_q;
				mreq.y = IW'(fd_q);
			end
			ST_FF: begin
				mreq.x = gain_ff_q;
				mreq.y = IW'(ffv_q);
			end
			ST_CDIV: begin
				dreq.n = clamp_hi_q ? (VW+2)'(out_max_q) : (VW+2)'(out_min_q);
				dreq.d = gain_i_q;
				dreq.wide = 1'b1;
			end
			ST_RAW: begin
				dreq.n = (VW+2)'(err_q) - (VW+2)'(prev_err_q);
				dreq.d = $signed(VW'(dt_q));
				dreq.sh_dt = 1'b1;
			end
			default: begin
			end
		endcase
		mreq.start = !issued_q && !is_div && (state_q != ST_IDLE) && (state_q != ST_SUM);
		dreq.start = !issued_q && is_div;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			ovalid_q <= 1'b0;
			gain_p_q <= RST_GAIN_P;
			gain_i_q <= '0;
			gain_d_q <= '0;
			gain_ff_q <= RST_GAIN_FF;
			alpha_q <= '0;
			out_min_q <= RST_OUT_MIN;
			out_max_q <= RST_OUT_MAX;
			offset_q <= '0;
			started_q <= 1'b0;
			prev_err_q <= '0;
			integ_q <= '0;
			fd_q <= '0;
			last_q <= '0;
		end else begin
			state_q <= state_d;
			if (op_done) begin
				issued_q <= 1'b0;
			end else if (mreq.start || dreq.start) begin
				issued_q <= 1'b1;
			end
			if (out_valid && out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GAIN_P: gain_p_q <= cfg_data;
					REG_GAIN_I: gain_i_q <= cfg_data;
					REG_GAIN_D: gain_d_q <= cfg_data;
					REG_GAIN_FF: gain_ff_q <= cfg_data;
					REG_ALPHA: alpha_q <= cfg_data[AW-1:0];
					REG_OUT_MIN: out_min_q <= cfg_data;
					REG_OUT_MAX: out_max_q <= cfg_data;
					REG_OFFSET: offset_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (mode) begin
					integ_q <= '0;
					ovalid_q <= 1'b1;
				end else if (!started_q) begin
					started_q <= 1'b1;
					ovalid_q <= 1'b1;
				end else if (elapsed_time == '0) begin
					ovalid_q <= 1'b1;
				end
			end
			if (op_done) begin
				unique case (state_q)
					ST_INC: begin
						if (gain_i_q == '0) begin
							integ_q <= '0;
						end else if (isum[IW] != isum[IW-1]) begin
							integ_q <= isum[IW] ? {1'b1, {(IW-1){1'b0}}}
								: {1'b0, {(IW-1){1'b1}}};
						end else begin
							integ_q <= isum[IW-1:0];
						end
					end
					ST_CDIV: integ_q <= op_res;
					ST_RAW: prev_err_q <= err_q;
					ST_FB: fd_q <= sat_v((VW+1)'(tmp_q) + (VW+1)'(res_v));
					default: begin
					end
				endcase
			end
			if (state_q == ST_SUM) begin
				last_q <= lc;
				ovalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= (!mode && !started_q) ? '0 : last_q;
			err_q <= sat_v((VW+1)'(setpoint) - (VW+1)'(measured_value));
			ffv_q <= feedforward_value;
			dt_q <= elapsed_time;
		end
		if (op_done) begin
			unique case (state_q)
				ST_P: sum_q <= SW'(res_v);
				ST_IT: begin
					clamp_hi_q <= res_v > out_max_q;
					if (!(res_v > out_max_q || res_v < out_min_q)) begin
						sum_q <= sum_q + SW'(res_v);
					end
				end
				ST_IT2, ST_D, ST_FF: sum_q <= sum_q + SW'(res_v);
				ST_RAW: raw_q <= res_v;
				ST_FA: tmp_q <= res_v;
				default: begin
				end
			endcase
		end
		if (state_q == ST_SUM) begin
			out_q <= lc;
		end
	end

	`PFD_ASSERT_IMP(a_ready_no_pending, clk, arst_n, in_ready, !out_valid)
	`PFD_ASSERT_NXT(a_accept_then_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	`PFD_ASSERT_IMP(a_one_unit_busy, clk, arst_n, msts.busy, !dsts.busy)
	`PFD_ASSERT_IMP(a_started_sticky, clk, arst_n, 1'b1, !$fell(started_q))

endmodule
